FILE: rtl/cfa_pkg.sv
// shared types and codes for the contiguous fit allocator
package cfa_pkg;

   localparam logic       OP_TICK  = 1'b0;
   localparam logic       OP_ALLOC = 1'b1;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_NEXT  = 2'd1;
   localparam logic [1:0] FIT_BEST  = 2'd2;

   localparam int REQ_BITS  = 7;
   localparam int HOLD_BITS = 15;
   localparam int SLOT_OUT  = 6;
   localparam int NOW_OUT   = 16;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic issue;
      logic mark_step;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic do_scan;
      logic issue_last;
      logic stop_early;
      logic found;
      logic mark_last;
      logic out_free;
      logic eval_pend;
   } ctl_sts_type;

endpackage

FILE: rtl/cfa_ram.sv
// generic single write, single registered read memory
module cfa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cfa_ctrl.sv
// sequencing state machine of the allocator
module cfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  cfa_pkg::ctl_sts_type sts,
   output cfa_pkg::ctl_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_DRAIN = 7'b0010000,
      ST_MARK  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = sts.do_scan ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (sts.stop_early) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               if (sts.issue_last) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last slot read to be evaluated
            if (!sts.eval_pend) state_in = sts.found ? ST_MARK : ST_DONE;
         end
         ST_MARK: begin
            cmd.mark_step = 1'b1;
            if (sts.mark_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

FILE: rtl/cfa_datapath.sv
// slot table, time counter, search and mark datapath
module cfa_datapath #(
   parameter int SLOTS     = 64,
   parameter int TIME_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cfa_pkg::ctl_cmd_type              cmd,
   output cfa_pkg::ctl_sts_type              sts,
   input  logic                              in_op,
   input  logic [cfa_pkg::REQ_BITS-1:0]      in_request_slots,
   input  logic [cfa_pkg::HOLD_BITS-1:0]     in_hold_time,
   input  logic                              csr_wr_en,
   input  logic [1:0]                        csr_wr_data,
   input  logic                              rsp_tready,
   output logic                              rsp_valid,
   output logic                              rsp_granted,
   output logic [cfa_pkg::SLOT_OUT-1:0]      rsp_start_slot,
   output logic [cfa_pkg::NOW_OUT-1:0]       rsp_now
);

   localparam int AW   = $clog2(SLOTS);
   localparam int LW   = $clog2(SLOTS + 1);
   localparam int CMPW = (LW > cfa_pkg::REQ_BITS) ? LW : cfa_pkg::REQ_BITS;
   localparam int RW   = TIME_BITS + 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

   logic [1:0]                   mode_ff;
   logic                         op_ff;
   logic                         ok_ff;
   logic [LW-1:0]                req_len_ff;
   logic [cfa_pkg::HOLD_BITS-1:0] hold_ff;
   logic [TIME_BITS-1:0]         time_ff;
   logic [AW-1:0]                ptr_ff;
   logic [AW-1:0]                issue_addr_ff;
   logic                         pass_ff;
   logic                         pend_ff;
   logic [AW-1:0]                eval_addr_ff;
   logic [LW-1:0]                run_ff;
   logic [AW-1:0]                hole_start_ff;
   logic                         found_ff;
   logic [LW-1:0]                best_len_ff;
   logic [AW-1:0]                start_ff;
   logic [AW-1:0]                off_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_granted_ff;
   logic [cfa_pkg::SLOT_OUT-1:0] rsp_start_ff;
   logic [cfa_pkg::NOW_OUT-1:0]  rsp_now_ff;

   logic                 is_next, is_best, is_tick, upd_en;
   logic [AW-1:0]        issue_next;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [RW-1:0]        ram_wdata;
   logic [RW-1:0]        ram_rdata;
   logic                 rd_busy;
   logic [TIME_BITS-1:0] rd_exp;
   logic [TIME_BITS-1:0] expiry;
   logic [LW-1:0]        run_base, run_n, hole_len;
   logic [AW-1:0]        hole_start_cur, cand_start;
   logic                 hole_close;
   logic                 req_ok_in;
   logic [LW:0]          ptr_sum;
   logic [LW:0]          mark_end;

   assign is_next = (mode_ff == cfa_pkg::FIT_NEXT);
   assign is_best = (mode_ff == cfa_pkg::FIT_BEST);
   assign is_tick = (op_ff == cfa_pkg::OP_TICK);
   assign upd_en  = is_best || !found_ff;

   assign issue_next = (issue_addr_ff == LAST_SLOT) ? '0 : issue_addr_ff + 1'b1;
   assign req_ok_in  = (in_request_slots != '0) &&
                       (CMPW'(in_request_slots) <= CMPW'(SLOTS));
   assign expiry     = TIME_BITS'(time_ff + TIME_BITS'(hold_ff));

   assign rd_busy = ram_rdata[TIME_BITS];
   assign rd_exp  = ram_rdata[TIME_BITS-1:0];

   // hole and run tracking on the slot just read
   always_comb begin
      run_base       = (eval_addr_ff == '0) ? '0 : run_ff;
      run_n          = run_base + 1'b1;
      hole_start_cur = (run_base == '0) ? eval_addr_ff : hole_start_ff;
      hole_close     = rd_busy || (eval_addr_ff == LAST_SLOT);
      hole_len       = rd_busy ? run_base : run_n;
      cand_start     = rd_busy ? hole_start_ff : hole_start_cur;
   end

   assign ptr_sum  = (LW+1)'(start_ff) + (LW+1)'(req_len_ff);
   assign mark_end = (LW+1)'(off_ff) + 1'b1;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = issue_addr_ff;
      ram_wdata = '0;
      if (cmd.clear_step) begin
         ram_we = 1'b1;
      end else if (pend_ff && is_tick) begin
         ram_we    = rd_busy && (rd_exp == time_ff);
         ram_waddr = eval_addr_ff;
         ram_wdata = {1'b0, rd_exp};
      end else if (cmd.mark_step) begin
         ram_we    = 1'b1;
         ram_waddr = AW'(start_ff + off_ff);
         ram_wdata = {1'b1, expiry};
      end
   end

   cfa_ram #(
      .WIDTH (RW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.issue),
      .rd_addr (issue_addr_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= cfa_pkg::FIT_FIRST;
         time_ff       <= '0;
         ptr_ff        <= '0;
         issue_addr_ff <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         pend_ff <= cmd.issue;
         if (cmd.clear_step || cmd.issue) issue_addr_ff <= issue_next;
         if (cmd.load) begin
            if (in_op == cfa_pkg::OP_TICK) time_ff <= time_ff + 1'b1;
            issue_addr_ff <= (in_op == cfa_pkg::OP_ALLOC && is_next) ? ptr_ff : '0;
            found_ff      <= 1'b0;
         end
         if (pend_ff && !is_tick && upd_en) begin
            if (is_best) begin
               if (hole_close && hole_len >= req_len_ff &&
                   (!found_ff || hole_len < best_len_ff)) begin
                  found_ff <= 1'b1;
               end
            end else if (!rd_busy && run_n == req_len_ff) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.mark_step && mark_end == (LW+1)'(req_len_ff) && is_next) begin
            ptr_ff <= (ptr_sum == (LW+1)'(SLOTS)) ? '0 : AW'(ptr_sum);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      eval_addr_ff <= issue_addr_ff;
      if (cmd.issue && issue_addr_ff == LAST_SLOT) pass_ff <= 1'b1;
      if (cmd.load) begin
         op_ff       <= in_op;
         ok_ff       <= req_ok_in;
         req_len_ff  <= LW'(in_request_slots);
         hold_ff     <= in_hold_time;
         pass_ff     <= 1'b0;
         run_ff      <= '0;
         best_len_ff <= '0;
         off_ff      <= '0;
      end
      if (pend_ff && !is_tick) begin
         run_ff        <= rd_busy ? '0 : run_n;
         hole_start_ff <= hole_start_cur;
         if (upd_en) begin
            if (is_best) begin
               if (hole_close && hole_len >= req_len_ff &&
                   (!found_ff || hole_len < best_len_ff)) begin
                  best_len_ff <= hole_len;
                  start_ff    <= cand_start;
               end
            end else if (!rd_busy && run_n == req_len_ff) begin
               start_ff <= AW'(LW'(eval_addr_ff) + 1'b1 - req_len_ff);
            end
         end
      end
      if (cmd.mark_step) off_ff <= off_ff + 1'b1;
      if (cmd.finish) begin
         rsp_granted_ff <= found_ff;
         rsp_start_ff   <= found_ff ? cfa_pkg::SLOT_OUT'(start_ff) : '0;
         rsp_now_ff     <= cfa_pkg::NOW_OUT'(time_ff);
      end
   end

   always_comb begin
      sts            = '0;
      sts.clear_last = (issue_addr_ff == LAST_SLOT);
      sts.do_scan    = is_tick || ok_ff;
      sts.issue_last = (issue_addr_ff == LAST_SLOT) &&
                       (is_tick || !is_next || pass_ff || ptr_ff == '0);
      sts.stop_early = found_ff && !is_best && !is_tick;
      sts.found      = found_ff && !is_tick;
      sts.mark_last  = (mark_end == (LW+1)'(req_len_ff));
      sts.out_free   = !rsp_valid_ff || rsp_tready;
      sts.eval_pend  = pend_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_start_slot = rsp_start_ff;
   assign rsp_now        = rsp_now_ff;

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_step |-> ((LW+1)'(start_ff) + (LW+1)'(off_ff)) < (LW+1)'(SLOTS))
      else $error("mark beyond last slot");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten");

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      (found_ff && !cmd.load) |=> found_ff)
      else $error("found flag lost");

endmodule

FILE: rtl/contiguous_fit_allocator.sv
// top level of the contiguous slot allocator with timed release
//
//  channel  direction  fields
//  req_     in         tuser: op; tdata: request_slots, hold_time
//  rsp_     out        tdata: granted, start_slot, now
//  csr_     in         fit_mode write, no read-back
//
// after reset a clearing pass writes every slot before the first request is taken
// tick: a scan of the whole slot table, one slot table read per cycle
// allocate: a scan of the slot table, then one mark step per granted slot; next fit starts at its pointer and may wrap
// a held result blocks only the completion of the following request
module contiguous_fit_allocator #(
   parameter int SLOTS     = 64,
   parameter int TIME_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // request_slots[6:0], hold_time[21:7], zero
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // granted[0], start_slot[6:1], now[22:7], zero
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   cfa_pkg::ctl_cmd_type cmd;
   cfa_pkg::ctl_sts_type sts;

   logic                         granted;
   logic [cfa_pkg::SLOT_OUT-1:0] start_slot;
   logic [cfa_pkg::NOW_OUT-1:0]  now;

   cfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cfa_datapath #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .in_op            (req_tuser),
      .in_request_slots (req_tdata[6:0]),
      .in_hold_time     (req_tdata[21:7]),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_granted      (granted),
      .rsp_start_slot   (start_slot),
      .rsp_now          (now)
   );

   assign rsp_tdata = {1'b0, now, start_slot, granted};

endmodule

FILE: verif/tb.sv
// testbench for the contiguous fit allocator: predicted grants checked against the response stream
module tb;

   localparam logic [1:0] FIT_SPARE = 2'd3;

   typedef struct packed {
      logic       op;
      logic [6:0] slots;
      logic [14:0] hold;
   } alloc_req_type;

   typedef struct packed {
      logic        granted;
      logic [5:0]  start;
      logic [15:0] now;
   } alloc_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_wr_en;
   logic [1:0]  csr_wr_data;

   contiguous_fit_allocator uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_grants[$];

   logic [1:0]  mode_shadow;
   logic        busy_map[64];
   logic [15:0] expiry_map[64];
   logic [15:0] clock_now;
   logic [5:0]  next_ptr;

   int  errors;
   int  grants_seen;
   int  rsp_count;
   int  stall_cycles;
   bit  quiet;
   bit  sender_hold;

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      $display("mismatch %0s: got %h want %h", what, got, want);
      errors++;
   endtask

   task automatic queue_req(input alloc_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   function automatic bit run_free(int s, int n);
      if (s + n > 64) return 0;
      for (int k = 0; k < n; k++) if (busy_map[s + k]) return 0;
      return 1;
   endfunction

   function automatic alloc_rsp_type predict_grant(alloc_req_type r);
      alloc_rsp_type o;
      int n, s, best_len, i, st, len;
      bit ok;
      o = '0;
      n = r.slots;
      ok = 0;
      s = 0;
      if (r.op == cfa_pkg::OP_TICK) begin
         clock_now = clock_now + 16'd1;
         for (i = 0; i < 64; i++)
            if (busy_map[i] && expiry_map[i] == clock_now) busy_map[i] = 0;
      end else if (n >= 1 && n <= 64) begin
         if (mode_shadow == cfa_pkg::FIT_NEXT) begin
            for (i = 0; i < 64 && !ok; i++) begin
               st = (next_ptr + i) % 64;
               if (run_free(st, n)) begin ok = 1; s = st; end
            end
         end else if (mode_shadow == cfa_pkg::FIT_BEST) begin
            best_len = 0;
            i = 0;
            while (i < 64) begin
               if (busy_map[i]) begin
                  i++;
               end else begin
                  st = i;
                  while (i < 64 && !busy_map[i]) i++;
                  len = i - st;
                  if (len >= n && (!ok || len < best_len)) begin
                     ok = 1; best_len = len; s = st;
                  end
               end
            end
         end else begin
            for (i = 0; i < 64 && !ok; i++)
               if (run_free(i, n)) begin ok = 1; s = i; end
         end
         if (ok) begin
            for (i = 0; i < n; i++) begin
               busy_map[s + i] = 1;
               expiry_map[s + i] = clock_now + 16'(r.hold);
            end
            if (mode_shadow == cfa_pkg::FIT_NEXT) next_ptr = 6'((s + n) % 64);
            o.granted = 1;
            o.start = 6'(s);
         end
      end
      o.now = clock_now;
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (sender_hold || pending_reqs.size() == 0 ||
                   (!quiet && $urandom_range(99) < 13)) begin
         req_tvalid <= 0;
      end else begin
         req_tvalid <= 1;
         req_tuser <= pending_reqs[0].op;
         req_tdata <= {2'b0, pending_reqs[0].hold, pending_reqs[0].slots};
         expected_grants.insert(expected_grants.size(),
                                predict_grant(pending_reqs.pop_front()));
      end
   end

   // monitor
   always @(posedge clock) begin
      alloc_rsp_type got, want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got = '{rsp_tdata[0], rsp_tdata[6:1], rsp_tdata[22:7]};
            if (expected_grants.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, '0);
            end else begin
               want = expected_grants.pop_front();
               if (got.granted != want.granted)
                  report_mismatch("granted", 24'(got.granted), 24'(want.granted));
               if (got.start != want.start)
                  report_mismatch("start_slot", 24'(got.start), 24'(want.start));
               if (got.now != want.now)
                  report_mismatch("now", 24'(got.now), 24'(want.now));
               if (want.granted) grants_seen++;
            end
         end
         rsp_tready <= quiet || $urandom_range(99) >= 13;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic alloc_req_type make_alloc(int n, int h);
      alloc_req_type r;
      r.op = cfa_pkg::OP_ALLOC;
      r.slots = 7'(n);
      r.hold = 15'(h);
      return r;
   endfunction

   function automatic alloc_req_type make_tick();
      alloc_req_type r;
      r.op = cfa_pkg::OP_TICK;
      r.slots = 7'($urandom);
      r.hold = 15'($urandom);
      return r;
   endfunction

   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_grants.size() == 0 && !req_tvalid);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_mode(logic [1:0] m);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 0;
      mode_shadow = m;
   endtask

   task automatic random_phase(int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 35)
            queue_req(make_tick());
         else if (roll < 45)
            queue_req(make_alloc($urandom_range(127), $urandom));
         else if (roll < 80)
            queue_req(make_alloc($urandom_range(1, 8), $urandom_range(1, 12)));
         else
            queue_req(make_alloc($urandom_range(1, 64), $urandom_range(0, 40)));
      end
   endtask

   initial begin
      logic [1:0] modes[6];
      modes = '{cfa_pkg::FIT_FIRST, cfa_pkg::FIT_NEXT, cfa_pkg::FIT_BEST, FIT_SPARE,
                cfa_pkg::FIT_NEXT, cfa_pkg::FIT_BEST};
      errors = 0; grants_seen = 0; rsp_count = 0;
      quiet = 0; sender_hold = 0;
      mode_shadow = cfa_pkg::FIT_FIRST; clock_now = 0; next_ptr = 0;
      for (int i = 0; i < 64; i++) begin busy_map[i] = 0; expiry_map[i] = 0; end
      reset = 1; req_tvalid = 0; req_tdata = '0; req_tuser = 0;
      rsp_tready = 0; csr_wr_en = 0; csr_wr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: extremes, zero and oversize requests, hold of zero, best fit holes
      set_mode(cfa_pkg::FIT_FIRST);
      queue_req(make_alloc(0, 5));
      queue_req(make_alloc(127, 5));
      queue_req(make_alloc(65, 5));
      queue_req(make_alloc(64, 2));
      queue_req(make_alloc(1, 1));
      queue_req(make_tick());
      queue_req(make_tick());
      queue_req(make_alloc(3, 1));
      queue_req(make_alloc(63, 32767));
      queue_req(make_alloc(1, 0));
      queue_req(make_tick());
      queue_req(make_alloc(1, 0));
      drain();
      set_mode(cfa_pkg::FIT_BEST);
      queue_req(make_alloc(1, 32767));
      queue_req(make_tick());
      queue_req(make_tick());
      queue_req(make_alloc(5, 3));
      queue_req(make_alloc(2, 1));
      queue_req(make_alloc(10, 2));
      queue_req(make_alloc(4, 9));
      queue_req(make_tick());
      queue_req(make_alloc(3, 4));
      queue_req(make_alloc(2, 4));
      drain();

      foreach (modes[m]) begin
         set_mode(modes[m]);
         quiet = (m == 2);
         random_phase(120);
         if (m == 3) begin
            wait (pending_reqs.size() < 60);
            sender_hold = 1;
            wait (expected_grants.size() == 0);
            sender_hold = 0;
         end
         drain();
      end
      quiet = 0;
      $display("covered %0d responses, %0d grants, all four fit mode codes", rsp_count,
               grants_seen);
      $display("time counter reached %0d, next fit pointer at %0d", clock_now, next_ptr);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
